>>> design/page_table_walker_unit_macros.svh
// Assertion macros of the page table walker, used by its walk sequencer
`ifndef PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define PGW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked on clock, off during reset
`define PGW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/pgw_pkg.sv
// Package with types, constants and helper functions of the page table walker
package pgw_pkg;

   localparam int STORE_WORDS = 4096;
   localparam int INDEX_BITS  = 9;
   localparam int PAGE_SHIFT  = 12;
   localparam int STORE_AW    = $clog2(STORE_WORDS);

   localparam logic [STORE_AW-1:0] STORE_LAST = STORE_AW'(STORE_WORDS - 1);

   localparam logic [63:0] NEXT_ADDR_MASK = 64'h000f_ffff_ffff_f000;
   localparam logic [63:0] VA_MASK        = 64'h0000_ffff_ffff_ffff;

   localparam int FLAG_PRESENT_BIT = 0;
   localparam int FLAG_LARGE_BIT   = 7;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_XLATE = 1'b1;

   localparam logic [1:0] LEVEL_LEAF = 2'd0;
   localparam logic [1:0] LEVEL_ROOT = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } walk_state_type;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [STORE_AW-1:0] addr;
      logic [63:0]         wr_data;
   } store_req_type;

   function automatic logic [INDEX_BITS-1:0] level_index(input logic [47:0] va,
                                                         input logic [1:0]  lvl);
      logic [INDEX_BITS-1:0] idx;
      unique case (lvl)
         2'd0:    idx = va[PAGE_SHIFT                  +: INDEX_BITS];
         2'd1:    idx = va[PAGE_SHIFT + INDEX_BITS     +: INDEX_BITS];
         2'd2:    idx = va[PAGE_SHIFT + 2 * INDEX_BITS +: INDEX_BITS];
         default: idx = va[PAGE_SHIFT + 3 * INDEX_BITS +: INDEX_BITS];
      endcase
      return idx;
   endfunction

   function automatic logic [STORE_AW-1:0] word_addr(input logic [63:0]           tbl,
                                                     input logic [INDEX_BITS-1:0] idx);
      logic [63:0] base;
      base = (tbl & NEXT_ADDR_MASK) >> 3;
      return STORE_AW'(base) + STORE_AW'(idx);
   endfunction

   function automatic logic [63:0] offset_mask(input logic [1:0] lvl);
      logic [63:0] m;
      unique case (lvl)
         2'd0:    m = (64'd1 << PAGE_SHIFT) - 64'd1;
         2'd1:    m = (64'd1 << (PAGE_SHIFT + INDEX_BITS)) - 64'd1;
         2'd2:    m = (64'd1 << (PAGE_SHIFT + 2 * INDEX_BITS)) - 64'd1;
         default: m = (64'd1 << (PAGE_SHIFT + 3 * INDEX_BITS)) - 64'd1;
      endcase
      return m;
   endfunction

endpackage

>>> design/page_table_walker_unit.sv
// Top level of the four-level page table walker with its root address register
// A write item stores one 64-bit entry into the table store; a translate item issues the
// root table read in its acceptance cycle, then reads each further level from the
// single-port store (registered read), for up to four levels until the stop level, a
// non-present entry or a large-page entry. The result sits in an output register, so
// the next item is taken while it waits; a result that finds that register still full
// is parked and holds the walker until it moves on. After reset the store is swept to
// zero, one word per cycle, and no item is accepted until the sweep ends; the root address
// register may be written at any time the block is idle.
module page_table_walker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [51:0] csr_root_table_addr,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [11:0] req_word_index,
   input  logic [63:0] req_entry_value,
   input  logic [47:0] req_virt_addr,
   input  logic [1:0]  req_stop_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_found_entry,
   output logic [1:0]  rsp_level_reached,
   output logic        rsp_entry_present,
   output logic [63:0] rsp_phys_addr
);
   import pgw_pkg::*;

   logic [51:0]   root_ff, root_in;
   store_req_type st_req;
   logic [63:0]   rd_data;
   logic          clearing;

   assign csr_ready = 1'b1;
   assign root_in   = (csr_valid && csr_ready) ? csr_root_table_addr : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   pgw_walker u_walker (
      .clock             (clock),
      .reset             (reset),
      .root_addr         (root_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_word_index    (req_word_index),
      .req_entry_value   (req_entry_value),
      .req_virt_addr     (req_virt_addr),
      .req_stop_level    (req_stop_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found_entry   (rsp_found_entry),
      .rsp_level_reached (rsp_level_reached),
      .rsp_entry_present (rsp_entry_present),
      .rsp_phys_addr     (rsp_phys_addr),
      .st_req            (st_req),
      .rd_data           (rd_data),
      .clearing          (clearing)
   );

   pgw_store u_store (
      .clock    (clock),
      .reset    (reset),
      .st_req   (st_req),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

endmodule

>>> design/pgw_store.sv
// Table store: single-port synchronous memory with a clearing sweep after reset
module pgw_store (
   input  logic                   clock,
   input  logic                   reset,
   input  pgw_pkg::store_req_type st_req,
   output logic [63:0]            rd_data,
   output logic                   clearing
);
   import pgw_pkg::*;

   logic [63:0]         tbl_mem_ff [STORE_WORDS];
   logic [63:0]         rd_data_ff;
   logic [STORE_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                clearing_ff, clearing_in;
   logic                mem_we;
   logic [STORE_AW-1:0] mem_waddr;
   logic [63:0]         mem_wdata;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + STORE_AW'(1);
         if (clr_addr_ff == STORE_LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = st_req.wr_en;
         mem_waddr = st_req.addr;
         mem_wdata = st_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (st_req.rd_en) begin
         rd_data_ff <= tbl_mem_ff[st_req.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

>>> design/pgw_walker.sv
// Walk sequencer: request intake, level-by-level table reads and result register
`include "page_table_walker_unit_macros.svh"

module pgw_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [51:0]            root_addr,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [11:0]            req_word_index,
   input  logic [63:0]            req_entry_value,
   input  logic [47:0]            req_virt_addr,
   input  logic [1:0]             req_stop_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_found_entry,
   output logic [1:0]             rsp_level_reached,
   output logic                   rsp_entry_present,
   output logic [63:0]            rsp_phys_addr,
   output pgw_pkg::store_req_type st_req,
   input  logic [63:0]            rd_data,
   input  logic                   clearing
);
   import pgw_pkg::*;

   walk_state_type state_ff, state_in;
   logic [47:0]    va_ff, va_in;
   logic [1:0]     stop_ff, stop_in;
   logic [1:0]     lvl_ff, lvl_in;
   logic [1:0]     lvl_dec;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_entry_ff, rsp_entry_in;
   logic [1:0]     rsp_level_ff, rsp_level_in;
   logic [63:0]    rsp_phys_ff, rsp_phys_in;

   logic [63:0]    pend_entry_ff, pend_entry_in;
   logic [1:0]     pend_level_ff, pend_level_in;
   logic [63:0]    pend_phys_ff, pend_phys_in;

   logic           res_valid;
   logic [63:0]    res_entry;
   logic [1:0]     res_level;
   logic [63:0]    res_phys;
   logic           walk_done;
   logic           slot_free;
   logic           accept;
   logic [63:0]    mask;

   assign lvl_dec   = lvl_ff - 2'd1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !clearing;
   assign accept    = req_valid && req_ready;
   assign mask      = offset_mask(lvl_ff);
   assign walk_done = (lvl_ff == stop_ff) || !rd_data[FLAG_PRESENT_BIT]
                      || rd_data[FLAG_LARGE_BIT] || (lvl_ff == LEVEL_LEAF);

   always_comb begin
      state_in      = state_ff;
      va_in         = va_ff;
      stop_in       = stop_ff;
      lvl_in        = lvl_ff;
      pend_entry_in = pend_entry_ff;
      pend_level_in = pend_level_ff;
      pend_phys_in  = pend_phys_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_phys_in   = rsp_phys_ff;
      st_req        = '0;
      res_valid     = 1'b0;
      res_entry     = '0;
      res_level     = '0;
      res_phys      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_WRITE) begin
                  st_req.wr_en   = 1'b1;
                  st_req.addr    = STORE_AW'(req_word_index);
                  st_req.wr_data = req_entry_value;
                  res_valid      = 1'b1;
               end else begin
                  st_req.rd_en = 1'b1;
                  st_req.addr  = word_addr(64'(root_addr),
                                           level_index(req_virt_addr, LEVEL_ROOT));
                  va_in        = req_virt_addr;
                  stop_in      = req_stop_level;
                  lvl_in       = LEVEL_ROOT;
                  state_in     = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               res_valid = 1'b1;
               res_entry = rd_data;
               res_level = lvl_ff;
               res_phys  = (rd_data & ~mask) | (64'(va_ff) & mask);
            end else begin
               st_req.rd_en = 1'b1;
               st_req.addr  = word_addr(rd_data, level_index(va_ff, lvl_dec));
               lvl_in       = lvl_dec;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = pend_entry_ff;
               rsp_level_in = pend_level_ff;
               rsp_phys_in  = pend_phys_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // deliver now if the output register frees up, else park the result
      if (res_valid) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_entry_in = res_entry;
            rsp_level_in = res_level;
            rsp_phys_in  = res_phys;
            state_in     = ST_IDLE;
         end else begin
            pend_entry_in = res_entry;
            pend_level_in = res_level;
            pend_phys_in  = res_phys;
            state_in      = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff         <= va_in;
      stop_ff       <= stop_in;
      lvl_ff        <= lvl_in;
      pend_entry_ff <= pend_entry_in;
      pend_level_ff <= pend_level_in;
      pend_phys_ff  <= pend_phys_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_phys_ff   <= rsp_phys_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found_entry   = rsp_entry_ff;
   assign rsp_level_reached = rsp_level_ff;
   assign rsp_entry_present = rsp_entry_ff[FLAG_PRESENT_BIT];
   assign rsp_phys_addr     = rsp_phys_ff;

   `PGW_ASSERT_IMP(a_no_accept_while_clearing, req_valid && req_ready, !clearing)
   `PGW_ASSERT_IMP(a_store_write_only_idle, st_req.wr_en, state_ff == ST_IDLE)
   `PGW_ASSERT_NXT(a_walk_follows_read, st_req.rd_en, state_ff == ST_WALK)
   `PGW_ASSERT_NXT(a_level_descends, (state_ff == ST_WALK) && (state_in == ST_WALK),
                   lvl_ff == $past(lvl_ff) - 2'd1)

endmodule

>>> tb/sv/page_table_walker_unit_tb.sv
// Self-checking testbench for page_table_walker_unit: table writes and page walks vs. a walk model
module page_table_walker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pgw_pkg::*;

   localparam int unsigned QUIET_LIMIT = 20000;
   localparam int unsigned PRINT_LIMIT = 200;

   typedef struct packed {
      logic        kind;
      logic [11:0] widx;
      logic [63:0] val;
      logic [47:0] va;
      logic [1:0]  stop;
   } walk_req_type;

   typedef struct packed {
      logic [63:0] entry;
      logic [1:0]  level;
      logic        present;
      logic [63:0] phys;
   } walk_rsp_type;

   class walk_tracker_type;
      logic [63:0]  words [STORE_WORDS];
      logic [51:0]  root;
      walk_rsp_type expected_walks[$];
      int unsigned  errors;

      function new();
         foreach (words[i]) words[i] = '0;
         root = '0;
         errors = 0;
      endfunction

      function void set_root(input logic [51:0] value);
         root = value;
      endfunction

      function int unsigned pending();
         return expected_walks.size();
      endfunction

      function void note_request(input walk_req_type it);
         walk_rsp_type r;
         logic [63:0]  tbl;
         logic [63:0]  ent;
         logic [63:0]  m;
         logic [8:0]   idx;
         int           lvl;
         bit           done;
         r = '0;
         if (it.kind == REQ_WRITE) begin
            words[it.widx] = it.val;
         end else begin
            tbl = {12'h0, root} & NEXT_ADDR_MASK;
            ent = '0;
            lvl = LEVEL_ROOT;
            done = 1'b0;
            for (int l = LEVEL_ROOT; l >= 0; l--) begin
               if (!done) begin
                  idx = 9'(it.va >> (PAGE_SHIFT + INDEX_BITS * l));
                  ent = words[STORE_AW'(tbl[STORE_AW+2:3] + idx)];
                  lvl = l;
                  if (l == int'(it.stop) || !ent[FLAG_PRESENT_BIT] || ent[FLAG_LARGE_BIT]) begin
                     done = 1'b1;
                  end else begin
                     tbl = ent & NEXT_ADDR_MASK;
                  end
               end
            end
            m = (64'd1 << (PAGE_SHIFT + INDEX_BITS * lvl)) - 64'd1;
            r.entry   = ent;
            r.level   = 2'(lvl);
            r.present = ent[FLAG_PRESENT_BIT];
            r.phys    = (ent & ~m) | ({16'h0, it.va} & m);
         end
         expected_walks.push_back(r);
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         if (errors < PRINT_LIMIT)
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(input walk_rsp_type got);
         walk_rsp_type want;
         if (expected_walks.size() == 0) begin
            report("result with no request", got.phys, '0);
         end else begin
            want = expected_walks.pop_front();
            if (got.entry !== want.entry) report("found_entry", got.entry, want.entry);
            if (got.level !== want.level) report("level_reached", 64'(got.level), 64'(want.level));
            if (got.present !== want.present)
               report("entry_present", 64'(got.present), 64'(want.present));
            if (got.phys !== want.phys) report("phys_addr", got.phys, want.phys);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [51:0] csr_root_table_addr;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [11:0] req_word_index;
   logic [63:0] req_entry_value;
   logic [47:0] req_virt_addr;
   logic [1:0]  req_stop_level;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_found_entry;
   logic [1:0]  rsp_level_reached;
   logic        rsp_entry_present;
   logic [63:0] rsp_phys_addr;

   walk_tracker_type tracker = new();
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   page_table_walker_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_root_table_addr (csr_root_table_addr),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_word_index      (req_word_index),
      .req_entry_value     (req_entry_value),
      .req_virt_addr       (req_virt_addr),
      .req_stop_level      (req_stop_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found_entry     (rsp_found_entry),
      .rsp_level_reached   (rsp_level_reached),
      .rsp_entry_present   (rsp_entry_present),
      .rsp_phys_addr       (rsp_phys_addr)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [47:0] rand_va();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic walk_req_type write_item(input logic [11:0] w, input logic [63:0] v);
      walk_req_type it;
      it.kind = REQ_WRITE;
      it.widx = w;
      it.val  = v;
      it.va   = rand_va();
      it.stop = 2'($urandom_range(3));
      return it;
   endfunction

   function automatic walk_req_type xlate_item(input logic [47:0] va, input logic [1:0] stop);
      walk_req_type it;
      it.kind = REQ_XLATE;
      it.widx = 12'($urandom_range(4095));
      it.val  = rand64();
      it.va   = va;
      it.stop = stop;
      return it;
   endfunction

   task automatic send_item(input walk_req_type it);
      if ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         while ($urandom_range(99) < req_idle_pct) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_type        <= it.kind;
      req_word_index  <= it.widx;
      req_entry_value <= it.val;
      req_virt_addr   <= it.va;
      req_stop_level  <= it.stop;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_request(it);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_root(input logic [51:0] value);
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_root_table_addr <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.set_root(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      walk_req_type seq[$];
      logic [63:0]  tbl;
      logic [63:0]  ent;
      logic [47:0]  va;
      logic [1:0]   stop;
      logic [8:0]   idx;
      int unsigned  sent;
      int unsigned  extra;
      sent = 0;
      while (sent < count) begin
         seq.delete();
         va   = rand_va();
         stop = 2'($urandom_range(3));
         if ($urandom_range(99) < 20) begin
            if ($urandom_range(1) == 0)
               seq.push_back(write_item(12'($urandom_range(4095)), rand64()));
            else
               seq.push_back(xlate_item(va, stop));
         end else begin
            // build the walk path, then translate along it
            tbl = {12'h0, tracker.root} & NEXT_ADDR_MASK;
            for (int l = LEVEL_ROOT; l >= int'(stop); l--) begin
               idx = 9'(va >> (PAGE_SHIFT + INDEX_BITS * l));
               ent = rand64();
               ent[FLAG_PRESENT_BIT] = ($urandom_range(99) < 92);
               if (l > int'(stop) && $urandom_range(99) < 85) ent[FLAG_LARGE_BIT] = 1'b0;
               seq.push_back(write_item(STORE_AW'(tbl[STORE_AW+2:3] + idx), ent));
               tbl = ent & NEXT_ADDR_MASK;
            end
            seq.push_back(xlate_item(va, stop));
            extra = $urandom_range(2);
            repeat (extra)
               seq.push_back(xlate_item(va ^ 48'($urandom_range(0, (1 << 21) - 1)),
                                        2'($urandom_range(3))));
         end
         foreach (seq[i]) send_item(seq[i]);
         sent += seq.size();
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         tracker.check_response({rsp_found_entry, rsp_level_reached, rsp_entry_present,
                                 rsp_phys_addr});
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [47:0] va_d;
      logic [47:0] va_wrap;
      va_d    = {9'd1, 9'd2, 9'd3, 9'd4, 12'habc};
      va_wrap = {9'd2, 9'd511, 30'h3fff_ffff};
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_root_table_addr = '0;
      req_valid           = 1'b0;
      req_type            = REQ_WRITE;
      req_word_index      = '0;
      req_entry_value     = '0;
      req_virt_addr       = '0;
      req_stop_level      = LEVEL_LEAF;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 32;
      rsp_idle_pct = 52;
      write_root(52'h0);
      send_item(xlate_item(48'h0, LEVEL_ROOT));
      send_item(xlate_item(48'hffff_ffff_ffff, LEVEL_LEAF));
      send_item(write_item(12'd0, 64'hffff_ffff_ffff_ffff));
      send_item(xlate_item(48'h0, LEVEL_LEAF));
      send_item(write_item(12'd1, 64'hfff0_0000_0000_1063));
      send_item(write_item(12'd514, 64'h0000_0000_0000_2001));
      send_item(write_item(12'd1027, 64'h0000_0000_0000_3001));
      send_item(write_item(12'd1540, 64'h8000_0000_abcd_e081));
      send_item(xlate_item(va_d, 2'd3));
      send_item(xlate_item(va_d, 2'd2));
      send_item(xlate_item(va_d, 2'd1));
      send_item(xlate_item(va_d, 2'd0));
      send_item(write_item(12'd514, 64'h0000_0000_0000_2081));
      send_item(xlate_item(va_d, LEVEL_LEAF));
      send_item(write_item(12'd514, 64'h0000_0000_0000_2001));
      send_item(write_item(12'd1027, 64'h0000_0000_0000_3081));
      send_item(xlate_item(va_d, LEVEL_LEAF));
      send_item(write_item(12'd1027, 64'h0000_0000_0000_3000));
      send_item(xlate_item(va_d, LEVEL_LEAF));
      send_item(xlate_item(va_d, 2'd1));
      send_item(write_item(12'd2, 64'h0000_0000_007f_f001));
      send_item(write_item(STORE_LAST, 64'hffff_ffff_ffff_ffff));
      send_item(xlate_item(va_wrap, 2'd2));
      send_item(write_item(12'd0, 64'h0));
      send_item(xlate_item(48'h0, 2'd1));
      drain();

      write_root(52'hf_ffff_ffff_ffff);
      run_random(150);
      drain();

      req_idle_pct = 52;
      rsp_idle_pct = 32;
      write_root(52'({$urandom(), $urandom()}));
      run_random(150);
      drain();

      // stall the result side long enough to back up the input
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_root(52'({$urandom(), $urandom()}));
      hold_left = 300;
      run_random(150);
      drain();

      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
